// ===== hw/rtl/set_assoc_lru_cache_lookup_core_defines.svh =====
// Assertion macros used by the top level of the set-associative LRU lookup RTL.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SALC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SALC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/salc_pkg.sv =====
// Shared types and constants of the set-associative LRU lookup.
`default_nettype none

package salc_pkg;

	localparam int ADDR_W       = 32;
	localparam int TAG_W        = 32;
	localparam int CFG_W        = 32;
	localparam int OFF_W        = 5;
	localparam int WAY_OUT_W    = 2;
	localparam int SET_OUT_W    = 6;
	localparam int GATHER_LANES = 4;
	localparam int GATHER_STEPS = ADDR_W / GATHER_LANES;
	localparam int STEP_W       = $clog2(GATHER_STEPS);

	localparam logic [OFF_W-1:0] OFFSET_RESET = 5'd2;
	localparam logic [CFG_W-1:0] MASK_RESET   = 32'd0;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_OFFSET_BITS = 1'b0;
	localparam cfg_idx_t REG_INDEX_MASK  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GATHER,
		ST_READ,
		ST_LOOK,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic gather;
		logic rd;
		logic look;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic gather_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/salc_if.sv =====
// Request and response channel interfaces of the LRU lookup.
`default_nettype none

interface salc_req_if;
	logic                       valid;
	logic                       ready;
	logic [salc_pkg::ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [salc_pkg::WAY_OUT_W-1:0] way;
	logic [salc_pkg::SET_OUT_W-1:0] set_index;

	modport source (output valid, output hit, output way, output set_index, input ready);
	modport sink   (input valid, input hit, input way, input set_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/salc_ctrl.sv =====
// Controller state machine of the LRU lookup.
`default_nettype none

module salc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire salc_pkg::status_t status,
	output salc_pkg::cmd_t         cmd
);

	salc_pkg::state_t state_q;
	salc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			salc_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = salc_pkg::ST_IDLE;
				end
			end
			salc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = salc_pkg::ST_GATHER;
				end
			end
			salc_pkg::ST_GATHER: begin
				cmd.gather = 1'b1;
				if (status.gather_last) begin
					state_d = salc_pkg::ST_READ;
				end
			end
			salc_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = salc_pkg::ST_LOOK;
			end
			salc_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = salc_pkg::ST_COMMIT;
			end
			salc_pkg::ST_COMMIT: begin
				// hold until the result register can take the item
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = salc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = salc_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/salc_dp.sv =====
// Datapath of the LRU lookup: config, index gather, set memories, LRU update, result.
`default_nettype none

module salc_dp #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire salc_pkg::cmd_t                  cmd,
	output salc_pkg::status_t                    status,
	input  wire logic                            cfg_we,
	input  wire salc_pkg::cfg_idx_t              cfg_idx,
	input  wire logic [salc_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic [salc_pkg::ADDR_W-1:0]     in_address,
	input  wire logic                            rsp_ready,
	output logic                                 rsp_valid,
	output logic                                 rsp_hit,
	output logic [salc_pkg::WAY_OUT_W-1:0]       rsp_way,
	output logic [salc_pkg::SET_OUT_W-1:0]       rsp_set_index
);

	localparam int ADDR_W = salc_pkg::ADDR_W;
	localparam int TAG_W  = salc_pkg::TAG_W;
	localparam int LANES  = salc_pkg::GATHER_LANES;
	localparam int STEP_W = salc_pkg::STEP_W;
	localparam int IDX_N  = $clog2(SETS + 1) - 1;
	localparam int IDX_W  = (IDX_N > 0) ? IDX_N : 1;
	localparam int GOT_W  = (IDX_N > 0) ? $clog2(IDX_N + 1) : 1;
	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RK_W   = WAY_W;
	localparam int CNT_W  = $clog2(WAYS + 1);

	// configuration
	logic [salc_pkg::OFF_W-1:0] offset_q;
	logic [salc_pkg::CFG_W-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= salc_pkg::OFFSET_RESET;
			mask_q   <= salc_pkg::MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				salc_pkg::REG_OFFSET_BITS: offset_q <= cfg_wdata[salc_pkg::OFF_W-1:0];
				salc_pkg::REG_INDEX_MASK:  mask_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// index gather, scanning from the top bit, LANES bits per step
	logic [ADDR_W-1:0] scan_addr_q;
	logic [ADDR_W-1:0] scan_mask_q;
	logic [TAG_W-1:0]  tag_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GOT_W-1:0]  got_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  g_idx;
	logic [GOT_W-1:0]  g_got;

	always_comb begin
		g_idx = idx_q;
		g_got = got_q;
		for (int k = 0; k < LANES; k++) begin
			if (scan_mask_q[ADDR_W-1-k] && (g_got < GOT_W'(IDX_N))) begin
				g_idx = IDX_W'({g_idx, scan_addr_q[ADDR_W-1-k]});
				g_got = g_got + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scan_addr_q <= in_address;
			scan_mask_q <= mask_q;
			tag_q       <= TAG_W'(in_address >> offset_q);
			idx_q       <= '0;
			got_q       <= '0;
			step_q      <= '0;
		end else if (cmd.gather) begin
			scan_addr_q <= scan_addr_q << LANES;
			scan_mask_q <= scan_mask_q << LANES;
			idx_q       <= g_idx;
			got_q       <= g_got;
			step_q      <= step_q + 1'b1;
		end
	end

	logic [SET_W-1:0] set_addr;
	assign set_addr = SET_W'(idx_q);

	// clearing pass over the set rows after reset
	logic [SET_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// set memories, one row per set
	logic [WAYS-1:0]       valid_mem [SETS];
	logic [WAYS*RK_W-1:0]  rank_mem  [SETS];
	logic [WAYS*TAG_W-1:0] tag_mem   [SETS];
	logic [WAYS-1:0]       rd_valid_q;
	logic [WAYS*RK_W-1:0]  rd_rank_q;
	logic [WAYS*TAG_W-1:0] rd_tag_q;
	logic [WAYS-1:0]       nxt_valid;
	logic [WAYS*RK_W-1:0]  nxt_rank;
	logic [WAYS*TAG_W-1:0] nxt_tag;
	logic [SET_W-1:0]      wr_addr;
	logic [WAYS-1:0]       wr_valid;
	logic [WAYS*RK_W-1:0]  wr_rank;

	assign wr_addr  = cmd.clear_wr ? clr_q : set_addr;
	assign wr_valid = cmd.clear_wr ? '0 : nxt_valid;
	assign wr_rank  = cmd.clear_wr ? '0 : nxt_rank;

	always_ff @(posedge clk) begin
		if (cmd.clear_wr || cmd.commit) begin
			valid_mem[wr_addr] <= wr_valid;
			rank_mem[wr_addr]  <= wr_rank;
		end
		if (cmd.commit) begin
			tag_mem[set_addr] <= nxt_tag;
		end
		if (cmd.rd) begin
			rd_valid_q <= valid_mem[set_addr];
			rd_rank_q  <= rank_mem[set_addr];
			rd_tag_q   <= tag_mem[set_addr];
		end
	end

	// tag compare and victim choice
	logic             hit_c;
	logic [WAY_W-1:0] hit_way;
	logic [RK_W-1:0]  hit_rank;
	logic             empty_c;
	logic [WAY_W-1:0] empty_way;
	logic [CNT_W-1:0] nvalid;
	logic [WAY_W-1:0] lru_way;
	logic [RK_W-1:0]  lru_rank;
	logic [WAY_W-1:0] sel_c;
	logic [RK_W-1:0]  old_c;

	always_comb begin
		hit_c     = 1'b0;
		hit_way   = '0;
		hit_rank  = '0;
		empty_c   = 1'b0;
		empty_way = '0;
		nvalid    = '0;
		lru_way   = '0;
		lru_rank  = rd_rank_q[RK_W-1:0];
		for (int w = 0; w < WAYS; w++) begin
			if (rd_valid_q[w]) begin
				nvalid = nvalid + 1'b1;
				if (!hit_c && (rd_tag_q[w*TAG_W +: TAG_W] == tag_q)) begin
					hit_c    = 1'b1;
					hit_way  = WAY_W'(w);
					hit_rank = rd_rank_q[w*RK_W +: RK_W];
				end
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!rd_valid_q[w]) begin
				empty_c   = 1'b1;
				empty_way = WAY_W'(w);
			end
		end
		// strict compare keeps the lowest way among equal oldest ranks
		for (int w = 1; w < WAYS; w++) begin
			if (rd_rank_q[w*RK_W +: RK_W] > lru_rank) begin
				lru_rank = rd_rank_q[w*RK_W +: RK_W];
				lru_way  = WAY_W'(w);
			end
		end
		if (hit_c) begin
			sel_c = hit_way;
			old_c = hit_rank;
		end else if (empty_c) begin
			sel_c = empty_way;
			old_c = RK_W'(nvalid);
		end else begin
			sel_c = lru_way;
			old_c = lru_rank;
		end
	end

	logic             hit_q;
	logic [WAY_W-1:0] sel_q;
	logic [RK_W-1:0]  old_rank_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q      <= hit_c;
			sel_q      <= sel_c;
			old_rank_q <= old_c;
		end
	end

	// row update: chosen way goes to rank zero, younger valid ways age by one
	always_comb begin
		nxt_valid = rd_valid_q;
		nxt_rank  = rd_rank_q;
		nxt_tag   = rd_tag_q;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == sel_q) begin
				nxt_valid[w]                = 1'b1;
				nxt_rank[w*RK_W +: RK_W]    = '0;
				if (!hit_q) begin
					nxt_tag[w*TAG_W +: TAG_W] = tag_q;
				end
			end else if (rd_valid_q[w] && (rd_rank_q[w*RK_W +: RK_W] < old_rank_q)) begin
				nxt_rank[w*RK_W +: RK_W] = rd_rank_q[w*RK_W +: RK_W] + 1'b1;
			end
		end
	end

	// result register
	logic                             out_valid_q;
	logic                             out_hit_q;
	logic [salc_pkg::WAY_OUT_W-1:0]   out_way_q;
	logic [salc_pkg::SET_OUT_W-1:0]   out_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q <= hit_q;
			out_way_q <= salc_pkg::WAY_OUT_W'(sel_q);
			out_set_q <= salc_pkg::SET_OUT_W'(idx_q);
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_hit       = out_hit_q;
	assign rsp_way       = out_way_q;
	assign rsp_set_index = out_set_q;

	assign status.clear_last  = (clr_q == SET_W'(SETS - 1));
	assign status.gather_last = (step_q == STEP_W'(salc_pkg::GATHER_STEPS - 1));
	assign status.out_free    = !out_valid_q || rsp_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_lru_cache_lookup_core.sv =====
// Top level of the set-associative cache lookup with LRU replacement.
//
//  channel | dir | payload                     | handshake
//  --------+-----+-----------------------------+-------------------
//  req     | in  | address[31:0]               | valid/ready
//  rsp     | out | hit, way[1:0], set_index[5:0]| valid/ready
//  cfg     | in  | cfg_idx, cfg_wdata[31:0]    | cfg_we, no stall
//
// One item at a time: accept, 8 gather steps of 4 address bits for the set
// index, one set-row read, one compare and victim choice, one write-back.
// The write-back waits while the result register still holds an unread item.
// After reset a clearing pass (one set row a cycle) runs first; no item is
// accepted during it, config writes are taken.
`default_nettype none

`include "set_assoc_lru_cache_lookup_core_defines.svh"

module set_assoc_lru_cache_lookup_core #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	salc_req_if.sink                        req,
	salc_rsp_if.source                      rsp,
	input  wire logic                       cfg_we,
	input  wire salc_pkg::cfg_idx_t         cfg_idx,
	input  wire logic [salc_pkg::CFG_W-1:0] cfg_wdata
);

	salc_pkg::cmd_t    cmd;
	salc_pkg::status_t status;
	logic              in_ready;

	// sequencer: clearing pass, then accept / gather / read / compare / write-back
	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// config registers, set memories, LRU logic and the result register
	salc_dp #(
		.SETS (SETS),
		.WAYS (WAYS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_address    (req.address),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.rsp_hit       (rsp.hit),
		.rsp_way       (rsp.way),
		.rsp_set_index (rsp.set_index)
	);

	// only one item in flight: an accept closes the input until write-back
	`SALC_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item accepted while busy")
	// a write-back always leaves a result waiting on the output
	`SALC_ASSERT_NXT(a_commit_shows, cmd.commit, rsp.valid, "write-back did not present a result")
	// the clearing pass keeps the input closed
	`SALC_ASSERT_IMP(a_clear_blocks, cmd.clear_wr, !req.ready, "input open during clearing pass")
	// controller issues at most one command a cycle
	`SALC_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "overlapping datapath commands")

endmodule

`default_nettype wire
